@@ hdl/sliding_window_event_counter_core_assert.svh @@
// ----------------------------------------------------------------------------
// Sliding window event counter - assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_EVENT_COUNTER_CORE_ASSERT_SVH
`define SLIDING_WINDOW_EVENT_COUNTER_CORE_ASSERT_SVH

// same-cycle implication
`define SWEC_AST_OVL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWEC_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/swec_pkg.sv @@
// ----------------------------------------------------------------------------
// swec_pkg
// Types and constants of the sliding window event counter.
// ----------------------------------------------------------------------------
package swec_pkg;

    localparam int NOW_W = 32;
    localparam int AMT_W = 16;
    localparam int SUM_W = 26;
    localparam int WIN_W = 16;

    localparam int SWEC_QUEUE_DEPTH = 1024;

    localparam logic [WIN_W-1:0] SHORT_WINDOW_RST = 16'd60;
    localparam logic [WIN_W-1:0] LONG_WINDOW_RST  = 16'd3600;

    // configuration register indexes
    localparam logic REG_SHORT_WINDOW = 1'b0;
    localparam logic REG_LONG_WINDOW  = 1'b1;

    typedef struct packed {
        logic [NOW_W-1:0] now_seconds;
        logic [AMT_W-1:0] amount;
    } t_swec_in;

    typedef struct packed {
        logic [SUM_W-1:0] short_total;
        logic [SUM_W-1:0] long_total;
        logic             dropped;
    } t_swec_out;

    typedef struct packed {
        logic [NOW_W-1:0] entry_time;
        logic [AMT_W-1:0] entry_amount;
    } t_entry;

    typedef enum logic {
        UOP_ADD,
        UOP_SUB
    } t_unit_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHORT_RD,
        ST_SHORT_CHK,
        ST_LONG_RD,
        ST_LONG_CHK,
        ST_APPEND_S,
        ST_APPEND_L
    } t_state;

    typedef struct packed {
        logic     mem_rd;
        logic     sel_long;
        t_unit_op op;
        logic     retire_short;
        logic     retire_long;
        logic     append_s;
        logic     append_l;
        logic     finish;
        logic     drop;
    } t_ctrl;

endpackage

@@ hdl/sliding_window_event_counter_core.sv @@
// ----------------------------------------------------------------------------
// sliding_window_event_counter_core
// Short and long sliding-window totals over a FIFO of (time, amount) events.
// ----------------------------------------------------------------------------
// Pulse start with an item while busy is low; busy stays high until the result
// appears on o_result for a single cycle with o_done, and the receiver must take
// it then since there is no hold-off. Each item checks the short window, then
// the long window, and then appends the event unless its amount is zero or the
// store is full; every aging check is a read of the event store followed by a
// compare in the shared unit, repeated while the oldest event has aged out. Each
// stored event ages out at most twice. The pace is set by the single read port.
// The user must write the window registers only while busy is low; the block
// itself does not enforce this. Store contents need no clearing after reset.
// ----------------------------------------------------------------------------
module sliding_window_event_counter_core
    import swec_pkg::*;
#(
    parameter int QUEUE_DEPTH = SWEC_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [WIN_W-1:0] i_cfg_wdata,
    input  logic             start,
    input  t_swec_in         i_item,
    output logic             busy,
    output logic             o_done,
    output t_swec_out        o_result
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int OW = $clog2(QUEUE_DEPTH + 1);

    t_state r_state, n_state;
    t_ctrl  ctl;

    logic [WIN_W-1:0] r_short_win, r_long_win;
    logic [NOW_W-1:0] r_now;
    logic [AMT_W-1:0] r_amount;
    logic [AW-1:0]    r_short_idx, n_short_idx;
    logic [AW-1:0]    r_oldest_idx, n_oldest_idx;
    logic [AW-1:0]    r_free_idx, n_free_idx;
    logic [OW-1:0]    r_short_occ, n_short_occ;
    logic [OW-1:0]    r_long_occ, n_long_occ;
    logic [SUM_W-1:0] r_short_sum, n_short_sum;
    logic [SUM_W-1:0] r_long_sum, n_long_sum;
    logic             r_done;
    t_swec_out        r_result;

    logic             short_go, long_go, full, app;
    t_entry           rd_data, wr_data;
    logic [AW-1:0]    rd_addr;
    logic             expired;
    logic [SUM_W-1:0] unit_sum;
    logic [AMT_W-1:0] unit_amount;

    function automatic logic [AW-1:0] f_adv(input logic [AW-1:0] idx);
        f_adv = (idx == AW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign short_go = r_short_occ != '0;
    assign long_go  = r_long_occ > r_short_occ;
    assign full     = r_long_occ == OW'(QUEUE_DEPTH);
    assign app      = (r_amount != '0) && !full;
    assign busy     = r_state != ST_IDLE;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (start) n_state = ST_SHORT_RD;
            ST_SHORT_RD:  n_state = short_go ? ST_SHORT_CHK : ST_LONG_RD;
            ST_SHORT_CHK: n_state = expired ? ST_SHORT_RD : ST_LONG_RD;
            ST_LONG_RD:   n_state = long_go ? ST_LONG_CHK : ST_APPEND_S;
            ST_LONG_CHK:  n_state = expired ? ST_LONG_RD : ST_APPEND_S;
            ST_APPEND_S:  n_state = app ? ST_APPEND_L : ST_IDLE;
            ST_APPEND_L:  n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        ctl    = '0;
        ctl.op = UOP_SUB;
        case (r_state)
            ST_SHORT_RD: begin
                ctl.mem_rd = short_go;
            end
            ST_SHORT_CHK: begin
                ctl.retire_short = expired;
            end
            ST_LONG_RD: begin
                ctl.sel_long = 1'b1;
                ctl.mem_rd   = long_go;
            end
            ST_LONG_CHK: begin
                ctl.sel_long    = 1'b1;
                ctl.retire_long = expired;
            end
            ST_APPEND_S: begin
                ctl.op       = UOP_ADD;
                ctl.append_s = app;
                ctl.finish   = !app;
                ctl.drop     = (r_amount != '0) && full;
            end
            ST_APPEND_L: begin
                ctl.op       = UOP_ADD;
                ctl.sel_long = 1'b1;
                ctl.append_l = 1'b1;
                ctl.finish   = 1'b1;
            end
            default: begin
                ctl.op = UOP_SUB;
            end
        endcase
    end

    assign rd_addr     = ctl.sel_long ? r_oldest_idx : r_short_idx;
    assign wr_data     = '{entry_time: r_now, entry_amount: r_amount};
    assign unit_amount = (ctl.op == UOP_ADD) ? r_amount : rd_data.entry_amount;

    swec_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (ctl.append_s),
        .i_wr_addr (r_free_idx),
        .i_wr_data (wr_data),
        .i_rd_en   (ctl.mem_rd),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    swec_unit u_unit (
        .i_time    (rd_data.entry_time),
        .i_window  (ctl.sel_long ? r_long_win : r_short_win),
        .i_now     (r_now),
        .i_sum     (ctl.sel_long ? r_long_sum : r_short_sum),
        .i_amount  (unit_amount),
        .i_op      (ctl.op),
        .o_expired (expired),
        .o_sum     (unit_sum)
    );

    always_comb begin
        n_short_sum  = (ctl.retire_short || ctl.append_s) ? unit_sum : r_short_sum;
        n_long_sum   = (ctl.retire_long || ctl.append_l) ? unit_sum : r_long_sum;
        n_short_idx  = ctl.retire_short ? f_adv(r_short_idx) : r_short_idx;
        n_oldest_idx = ctl.retire_long ? f_adv(r_oldest_idx) : r_oldest_idx;
        n_free_idx   = ctl.append_s ? f_adv(r_free_idx) : r_free_idx;
        n_short_occ  = r_short_occ;
        n_long_occ   = r_long_occ;
        if (ctl.retire_short) begin
            n_short_occ = r_short_occ - 1'b1;
        end else if (ctl.append_s) begin
            n_short_occ = r_short_occ + 1'b1;
        end
        if (ctl.retire_long) begin
            n_long_occ = r_long_occ - 1'b1;
        end else if (ctl.append_s) begin
            n_long_occ = r_long_occ + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_short_win  <= SHORT_WINDOW_RST;
            r_long_win   <= LONG_WINDOW_RST;
            r_short_idx  <= '0;
            r_oldest_idx <= '0;
            r_free_idx   <= '0;
            r_short_occ  <= '0;
            r_long_occ   <= '0;
            r_short_sum  <= '0;
            r_long_sum   <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_short_idx  <= n_short_idx;
            r_oldest_idx <= n_oldest_idx;
            r_free_idx   <= n_free_idx;
            r_short_occ  <= n_short_occ;
            r_long_occ   <= n_long_occ;
            r_short_sum  <= n_short_sum;
            r_long_sum   <= n_long_sum;
            r_done       <= ctl.finish;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SHORT_WINDOW: r_short_win <= i_cfg_wdata;
                    REG_LONG_WINDOW:  r_long_win  <= i_cfg_wdata;
                    default:          r_short_win <= r_short_win;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_now    <= i_item.now_seconds;
            r_amount <= i_item.amount;
        end
        if (ctl.finish) begin
            r_result <= '{short_total: n_short_sum, long_total: n_long_sum,
                          dropped: ctl.drop};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ hdl/swec_mem.sv @@
// ----------------------------------------------------------------------------
// swec_mem
// Event store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module swec_mem
    import swec_pkg::*;
#(
    parameter int DEPTH = SWEC_QUEUE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/swec_unit.sv @@
// ----------------------------------------------------------------------------
// swec_unit
// Shared arithmetic unit: window expiry compare and running-sum add/subtract.
// ----------------------------------------------------------------------------
module swec_unit
    import swec_pkg::*;
(
    input  logic [NOW_W-1:0] i_time,
    input  logic [WIN_W-1:0] i_window,
    input  logic [NOW_W-1:0] i_now,
    input  logic [SUM_W-1:0] i_sum,
    input  logic [AMT_W-1:0] i_amount,
    input  t_unit_op         i_op,
    output logic             o_expired,
    output logic [SUM_W-1:0] o_sum
);

    logic [NOW_W:0] time_plus_win;

    // time + window <= now, one carry bit wide so it never wraps
    assign time_plus_win = {1'b0, i_time} + {{(NOW_W+1-WIN_W){1'b0}}, i_window};
    assign o_expired     = time_plus_win <= {1'b0, i_now};

    always_comb begin
        case (i_op)
            UOP_ADD: o_sum = i_sum + SUM_W'(i_amount);
            UOP_SUB: o_sum = i_sum - SUM_W'(i_amount);
            default: o_sum = i_sum;
        endcase
    end

endmodule

@@ hdl/swec_chk.sv @@
// ----------------------------------------------------------------------------
// swec_chk
// Port-level checks of the command handshake and result strobe timing.
// ----------------------------------------------------------------------------
`include "sliding_window_event_counter_core_assert.svh"

module swec_chk
    import swec_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_done,
    input t_swec_out o_result
);

    // a taken transaction raises busy in the cycle after it is taken
    `SWEC_AST_NXT(a_start_busy, start && !busy, busy, "busy not raised after start")
    // a result only ends a busy period
    `SWEC_AST_OVL(a_done_end, o_done, !busy && $past(busy), "result outside a transaction")
    // every busy period ends with exactly one result
    `SWEC_AST_OVL(a_fell_done, $fell(busy), o_done, "transaction ended without result")
    // the result ports keep their value as the strobe falls, unless start is high
    `SWEC_AST_OVL(a_drop_valid, !o_done && $past(o_done), $stable(o_result) || start,
        "result changed without a transaction")

endmodule

bind sliding_window_event_counter_core swec_chk u_swec_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
